// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the colormap row generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every rising clock edge outside reset.
`define CMRG_ASSERT(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a consequent holds whenever the antecedent holds.
`define CMRG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/cmrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmrg_pkg
// Types, codes and constants of the colormap row generator.
// ----------------------------------------------------------------------------
package cmrg_pkg;

   localparam int ROWS = 256;

   localparam logic [16:0] ONE = 17'h10000;

   // Divider remainder width: holds ROWS * ONE and twice a remainder.
   localparam int REM_W = ($clog2(ROWS) + 18 > 25) ? ($clog2(ROWS) + 18) : 25;
   localparam int QUO_W = 16;
   localparam int DIV_STAGES = 8;
   localparam int BITS_PER_STAGE = QUO_W / DIV_STAGES;

   // Register indexes
   localparam logic [2:0] CSR_MODE        = 3'd0;
   localparam logic [2:0] CSR_RANGE_LOW   = 3'd1;
   localparam logic [2:0] CSR_RANGE_HIGH  = 3'd2;
   localparam logic [2:0] CSR_CONST_HUE   = 3'd3;
   localparam logic [2:0] CSR_CONST_SAT   = 3'd4;
   localparam logic [2:0] CSR_CONST_VAL   = 3'd5;
   localparam logic [2:0] CSR_CONST_ALPHA = 3'd6;

   // Table kinds
   localparam logic [3:0] MODE_BLACK     = 4'd0;
   localparam logic [3:0] MODE_GRAY      = 4'd1;
   localparam logic [3:0] MODE_INV_GRAY  = 4'd2;
   localparam logic [3:0] MODE_RED       = 4'd3;
   localparam logic [3:0] MODE_GREEN     = 4'd4;
   localparam logic [3:0] MODE_BLUE      = 4'd5;
   localparam logic [3:0] MODE_ALPHA     = 4'd6;
   localparam logic [3:0] MODE_HSV_HUE   = 4'd7;
   localparam logic [3:0] MODE_HSV_HUEV  = 4'd8;
   localparam logic [3:0] MODE_HSV_SAT   = 4'd9;
   localparam logic [3:0] MODE_HSV_VAL   = 4'd10;
   localparam logic [3:0] MODE_HSV_ALPHA = 4'd11;

   typedef struct packed {
      logic [7:0] row_index;
      logic [3:0] slice_index;
   } cmrg_req_type;

   typedef struct packed {
      logic [16:0] red;
      logic [16:0] green;
      logic [16:0] blue;
      logic [16:0] alpha;
      logic [7:0]  row_out;
      logic [3:0]  slice_out;
   } cmrg_rsp_type;

   // Saturated register values as seen by the datapath
   typedef struct packed {
      logic [3:0]  mode;
      logic [16:0] range_low;
      logic [16:0] range_high;
      logic [16:0] const_hue;
      logic [16:0] const_sat;
      logic [16:0] const_val;
      logic [16:0] const_alpha;
   } cmrg_cfg_type;

   typedef struct packed {
      logic [16:0] ramp;
      logic [7:0]  row;
      logic [3:0]  slice;
   } cmrg_ramp_type;

   function automatic logic [16:0] sat_one(logic [16:0] v);
      return (v > ONE) ? ONE : v;
   endfunction

endpackage

// ===== rtl/colormap_row_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colormap_row_generator
// One RGBA colormap entry per table row, Q1.16 components.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per table row (row index, slice index). A beat is
//   taken on a clock edge with req_valid high and req_stall low.
//   rsp_* returns one beat per request, in order, with RGBA and the echoed
//   row and slice; the consumer holds it off with rsp_stall.
//   csr_* writes the seven registers (mode, range ends, HSV constants); it is
//   always ready. Write only while no request is in flight.
// Stages from request beat to response beat:
//   one compare stage, eight divider stages (two quotient bits each), and
//   four color stages ending in the result register.
// Throughput: one beat per cycle while not stalled; every stage, the
//   divider included, takes a new beat each cycle.
// Stalls: each stage holds while the one after it is full and stalled, so
//   bubbles close up and a new request is still taken while a result waits.
// Reset: clears all stage valids and loads the registers with gray mode,
//   full range and unit saturation, value and alpha.
// ----------------------------------------------------------------------------
module colormap_row_generator import cmrg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  cmrg_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output cmrg_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [16:0]  csr_wdata
);

   cmrg_cfg_type  cfg;
   logic          ramp_valid;
   logic          ramp_stall;
   cmrg_ramp_type ramp_data;

   // Register file; range and HSV constant values are saturated to one before use
   cmrg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Row to ramp level: signed compare, then long division of the offset
   cmrg_ramp u_ramp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (ramp_valid),
      .out_stall (ramp_stall),
      .out_data  (ramp_data)
   );

   // Ramp to color: table kind select and HSV conversion
   cmrg_color u_color (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (ramp_valid),
      .in_stall  (ramp_stall),
      .in_data   (ramp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/cmrg_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmrg_csr
// Configuration registers; presents saturated values to the datapath.
// ----------------------------------------------------------------------------
module cmrg_csr import cmrg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [16:0]  csr_wdata,
   output cmrg_cfg_type cfg
);

   logic [3:0]  mode_ff;
   logic [16:0] low_ff;
   logic [16:0] high_ff;
   logic [16:0] hue_ff;
   logic [16:0] sat_ff;
   logic [16:0] val_ff;
   logic [16:0] alpha_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_GRAY;
         low_ff   <= '0;
         high_ff  <= ONE;
         hue_ff   <= '0;
         sat_ff   <= ONE;
         val_ff   <= ONE;
         alpha_ff <= ONE;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:        mode_ff  <= csr_wdata[3:0];
            CSR_RANGE_LOW:   low_ff   <= csr_wdata;
            CSR_RANGE_HIGH:  high_ff  <= csr_wdata;
            CSR_CONST_HUE:   hue_ff   <= csr_wdata;
            CSR_CONST_SAT:   sat_ff   <= csr_wdata;
            CSR_CONST_VAL:   val_ff   <= csr_wdata;
            CSR_CONST_ALPHA: alpha_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.mode        = mode_ff;
      cfg.range_low   = sat_one(low_ff);
      cfg.range_high  = sat_one(high_ff);
      cfg.const_hue   = sat_one(hue_ff);
      cfg.const_sat   = sat_one(sat_ff);
      cfg.const_val   = sat_one(val_ff);
      cfg.const_alpha = sat_one(alpha_ff);
   end

endmodule

// ===== rtl/cmrg_ramp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// cmrg_ramp
// Ramp value per row: front compare stage and a pipelined long divider.
// ----------------------------------------------------------------------------
module cmrg_ramp import cmrg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cmrg_cfg_type  cfg,
   input  logic          in_valid,
   output logic          in_stall,
   input  cmrg_req_type  in_data,
   output logic          out_valid,
   input  logic          out_stall,
   output cmrg_ramp_type out_data
);

   typedef struct packed {
      logic               force_zero;
      logic               force_one;
      logic [REM_W-1:0]   rem;
      logic [QUO_W-1:0]   quo;
      logic [7:0]         row;
      logic [3:0]         slice;
   } cmrg_div_type;

   function automatic cmrg_div_type div_step(cmrg_div_type s, logic [REM_W-1:0] d);
      cmrg_div_type     o;
      logic [REM_W-1:0] r2;
      o = s;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
         r2 = o.rem << 1;
         if (r2 >= d) begin
            o.rem = r2 - d;
            o.quo = {o.quo[QUO_W-2:0], 1'b1};
         end else begin
            o.rem = r2;
            o.quo = {o.quo[QUO_W-2:0], 1'b0};
         end
      end
      return o;
   endfunction

   logic [REM_W-1:0] lev;
   logic [REM_W-1:0] base;
   logic [REM_W-1:0] mag;
   logic [REM_W-1:0] den;
   logic [16:0]      span;
   logic             lev_ge;
   logic             step;
   logic             zero_raw;
   cmrg_div_type     front;

   cmrg_div_type       stg_ff [0:DIV_STAGES];
   logic [DIV_STAGES:0] vld_ff;
   logic [DIV_STAGES:0] adv;

   // Divisor depends on configuration only
   always_comb begin
      span = (cfg.range_high >= cfg.range_low) ? (cfg.range_high - cfg.range_low)
                                               : (cfg.range_low - cfg.range_high);
      den  = REM_W'(span) * REM_W'(ROWS);
   end

   // Sign, step and clamp decisions; what is left is a 16 bit fraction
   always_comb begin
      lev      = REM_W'(in_data.row_index) << 16;
      base     = REM_W'(cfg.range_low) * REM_W'(ROWS);
      lev_ge   = (lev >= base);
      mag      = lev_ge ? (lev - base) : (base - lev);
      step     = (cfg.range_high == cfg.range_low);
      zero_raw = (mag == '0) || ((!lev_ge) != (cfg.range_high < cfg.range_low));
      front.force_zero = step ? !lev_ge : zero_raw;
      front.force_one  = step ? lev_ge : (!zero_raw && (mag >= den));
      front.rem   = (front.force_zero || front.force_one) ? '0 : mag;
      front.quo   = '0;
      front.row   = in_data.row_index;
      front.slice = in_data.slice_index;
   end

   // A stage advances when empty or when the next one advances
   always_comb begin
      adv[DIV_STAGES] = !vld_ff[DIV_STAGES] || !out_stall;
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign in_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k <= DIV_STAGES; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) stg_ff[0] <= front;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         if (adv[k]) stg_ff[k] <= div_step(stg_ff[k-1], den);
      end
   end

   assign out_valid = vld_ff[DIV_STAGES];

   always_comb begin
      if (stg_ff[DIV_STAGES].force_zero) begin
         out_data.ramp = '0;
      end else if (stg_ff[DIV_STAGES].force_one) begin
         out_data.ramp = ONE;
      end else begin
         out_data.ramp = {1'b0, stg_ff[DIV_STAGES].quo};
      end
      out_data.row   = stg_ff[DIV_STAGES].row;
      out_data.slice = stg_ff[DIV_STAGES].slice;
   end

   `CMRG_ASSERT(a_force_excl, clock, reset, !(vld_ff[0] && stg_ff[0].force_zero && stg_ff[0].force_one), "ramp forced to zero and one at once")
   `CMRG_ASSERT_IMP(a_rem_below_den, clock, reset, vld_ff[DIV_STAGES] && !stg_ff[DIV_STAGES].force_zero && !stg_ff[DIV_STAGES].force_one, stg_ff[DIV_STAGES].rem < den, "divider remainder not below divisor")

endmodule

// ===== rtl/cmrg_color.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// cmrg_color
// Component select, HSV to RGB in three stages, and the result register.
// ----------------------------------------------------------------------------
module cmrg_color import cmrg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cmrg_cfg_type  cfg,
   input  logic          in_valid,
   output logic          in_stall,
   input  cmrg_ramp_type in_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output cmrg_rsp_type  rsp_data
);

   typedef struct packed {
      logic [16:0] sat;
      logic [16:0] val;
      logic [16:0] alp;
      logic [2:0]  sec;
      logic [15:0] frac;
      cmrg_ramp_type rd;
   } cmrg_c1_type;

   typedef struct packed {
      logic [16:0] p;
      logic [16:0] fs;
      logic [16:0] gs;
      logic [16:0] val;
      logic [16:0] alp;
      logic [2:0]  sec;
      cmrg_ramp_type rd;
   } cmrg_c2_type;

   typedef struct packed {
      logic [16:0] p;
      logic [16:0] q;
      logic [16:0] t;
      logic [16:0] val;
      logic [16:0] alp;
      logic [2:0]  sec;
      cmrg_ramp_type rd;
   } cmrg_c3_type;

   cmrg_c1_type  c1_in, c1_ff;
   cmrg_c2_type  c2_in, c2_ff;
   cmrg_c3_type  c3_in, c3_ff;
   cmrg_rsp_type rsp_in, rsp_ff;
   logic [3:0]   vld_ff;
   logic [3:0]   adv;

   logic [16:0] hue;
   logic [18:0] h6;
   logic [33:0] prod_fs, prod_gs, prod_p, prod_q, prod_t;
   logic [16:0] r3, g3, b3;

   // Stage 1: pick the ramped components, split hue into sector and fraction
   always_comb begin
      hue       = (cfg.mode == MODE_HSV_HUE || cfg.mode == MODE_HSV_HUEV)
                  ? in_data.ramp : cfg.const_hue;
      c1_in.sat = (cfg.mode == MODE_HSV_SAT) ? in_data.ramp : cfg.const_sat;
      c1_in.val = (cfg.mode == MODE_HSV_HUEV || cfg.mode == MODE_HSV_VAL)
                  ? in_data.ramp : cfg.const_val;
      c1_in.alp = (cfg.mode == MODE_HSV_ALPHA) ? in_data.ramp : cfg.const_alpha;
      h6        = 19'(hue) * 19'd6;
      // hue of one wraps to sector zero
      if (h6[18:16] >= 3'd6) begin
         c1_in.sec  = 3'd0;
         c1_in.frac = '0;
      end else begin
         c1_in.sec  = h6[18:16];
         c1_in.frac = h6[15:0];
      end
      c1_in.rd = in_data;
   end

   // Stage 2: first level of products
   always_comb begin
      prod_fs  = 34'(c1_ff.frac) * 34'(c1_ff.sat);
      prod_gs  = 34'(ONE - {1'b0, c1_ff.frac}) * 34'(c1_ff.sat);
      prod_p   = 34'(c1_ff.val) * 34'(ONE - c1_ff.sat);
      c2_in.fs  = prod_fs[32:16];
      c2_in.gs  = prod_gs[32:16];
      c2_in.p   = prod_p[32:16];
      c2_in.val = c1_ff.val;
      c2_in.alp = c1_ff.alp;
      c2_in.sec = c1_ff.sec;
      c2_in.rd  = c1_ff.rd;
   end

   // Stage 3: scale by value
   always_comb begin
      prod_q   = 34'(c2_ff.val) * 34'(ONE - c2_ff.fs);
      prod_t   = 34'(c2_ff.val) * 34'(ONE - c2_ff.gs);
      c3_in.q   = prod_q[32:16];
      c3_in.t   = prod_t[32:16];
      c3_in.p   = c2_ff.p;
      c3_in.val = c2_ff.val;
      c3_in.alp = c2_ff.alp;
      c3_in.sec = c2_ff.sec;
      c3_in.rd  = c2_ff.rd;
   end

   // Stage 4: sector rotation and table kind
   always_comb begin
      unique case (c3_ff.sec)
         3'd0:    begin r3 = c3_ff.val; g3 = c3_ff.t;   b3 = c3_ff.p;   end
         3'd1:    begin r3 = c3_ff.q;   g3 = c3_ff.val; b3 = c3_ff.p;   end
         3'd2:    begin r3 = c3_ff.p;   g3 = c3_ff.val; b3 = c3_ff.t;   end
         3'd3:    begin r3 = c3_ff.p;   g3 = c3_ff.q;   b3 = c3_ff.val; end
         3'd4:    begin r3 = c3_ff.t;   g3 = c3_ff.p;   b3 = c3_ff.val; end
         default: begin r3 = c3_ff.val; g3 = c3_ff.p;   b3 = c3_ff.q;   end
      endcase
      rsp_in.red   = '0;
      rsp_in.green = '0;
      rsp_in.blue  = '0;
      rsp_in.alpha = ONE;
      unique case (cfg.mode)
         MODE_GRAY: begin
            rsp_in.red   = c3_ff.rd.ramp;
            rsp_in.green = c3_ff.rd.ramp;
            rsp_in.blue  = c3_ff.rd.ramp;
         end
         MODE_INV_GRAY: begin
            rsp_in.red   = ONE - c3_ff.rd.ramp;
            rsp_in.green = ONE - c3_ff.rd.ramp;
            rsp_in.blue  = ONE - c3_ff.rd.ramp;
         end
         MODE_RED:   rsp_in.red   = c3_ff.rd.ramp;
         MODE_GREEN: rsp_in.green = c3_ff.rd.ramp;
         MODE_BLUE:  rsp_in.blue  = c3_ff.rd.ramp;
         MODE_ALPHA: rsp_in.alpha = c3_ff.rd.ramp;
         MODE_HSV_HUE, MODE_HSV_HUEV, MODE_HSV_SAT, MODE_HSV_VAL,
         MODE_HSV_ALPHA: begin
            rsp_in.red   = r3;
            rsp_in.green = g3;
            rsp_in.blue  = b3;
            rsp_in.alpha = c3_ff.alp;
         end
         default: rsp_in.alpha = '0;
      endcase
      rsp_in.row_out   = c3_ff.rd.row;
      rsp_in.slice_out = c3_ff.rd.slice;
   end

   always_comb begin
      adv[3] = !vld_ff[3] || !rsp_stall;
      adv[2] = !vld_ff[2] || adv[3];
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
   end

   assign in_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         if (adv[1]) vld_ff[1] <= vld_ff[0];
         if (adv[2]) vld_ff[2] <= vld_ff[1];
         if (adv[3]) vld_ff[3] <= vld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) c1_ff  <= c1_in;
      if (adv[1]) c2_ff  <= c2_in;
      if (adv[2]) c3_ff  <= c3_in;
      if (adv[3]) rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[3];
   assign rsp_data  = rsp_ff;

   `CMRG_ASSERT_IMP(a_rsp_in_range, clock, reset, rsp_valid, rsp_data.red <= ONE && rsp_data.green <= ONE && rsp_data.blue <= ONE && rsp_data.alpha <= ONE, "result component above one")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colormap row generator testbench
// Drives request beats through the generator under random idling on both
// channels, predicts each RGBA entry from its own ramp and HSV arithmetic
// or takes a typed-in one, and compares every response beat in order. Runs
// several register settings, written only while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
   import cmrg_pkg::*;

   localparam int LATENCY    = 13;
   localparam int WDOG_LIMIT = 4000;
   localparam int N_RANDOM   = 1050;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   cmrg_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   cmrg_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [16:0]  csr_wdata = '0;

   colormap_row_generator dut (.*);

   always #5 clock = ~clock;

   // Shadow copy of the registers as written
   logic [3:0]   sh_mode;
   logic [16:0]  sh_low, sh_high, sh_hue, sh_sat, sh_val, sh_alpha;

   cmrg_rsp_type expected_entries[$];
   int           error_count = 0;
   int           beats_in = 0;
   int           beats_out = 0;
   int           idle_cycles = 0;
   int           settings_run = 0;
   bit           calm = 1'b0;   // no idling in the last part of the run

   task automatic report_mismatch(input string what, input logic [16:0] got,
                                  input logic [16:0] want);
      error_count++;
      $display("mismatch beat %0d %s: got %0d want %0d", beats_out, what, got, want);
   endtask

   function automatic logic [16:0] clamp_one(logic [16:0] v);
      return (v > 17'h10000) ? 17'h10000 : v;
   endfunction

   function automatic logic [16:0] ramp_of_row(logic [7:0] row);
      longint lo, hi, lev, base, num, den, q;
      lo   = clamp_one(sh_low);
      hi   = clamp_one(sh_high);
      lev  = longint'(row) * 65536;
      base = lo * ROWS;
      if (hi == lo) return (lev >= base) ? 17'h10000 : 17'h0;
      num = (lev - base) * 65536;
      den = longint'(ROWS) * (hi - lo);
      if (num == 0 || ((num < 0) != (den < 0))) return 17'h0;
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      q = num / den;
      return (q > 65536) ? 17'h10000 : q[16:0];
   endfunction

   function automatic logic [16:0] fix_mul(logic [16:0] a, logic [16:0] b);
      logic [33:0] prod;
      prod = 34'(a) * 34'(b);
      return prod[32:16];
   endfunction

   function automatic cmrg_rsp_type predict_entry(cmrg_req_type rq);
      cmrg_rsp_type e;
      logic [16:0]  r, h, s, v, a, f, p, q, t;
      logic [19:0]  h6;
      logic [3:0]   sector;
      bit           hsv;
      r = ramp_of_row(rq.row_index);
      h = clamp_one(sh_hue);
      s = clamp_one(sh_sat);
      v = clamp_one(sh_val);
      a = clamp_one(sh_alpha);
      hsv = 1'b0;
      e = '0;
      case (sh_mode)
         MODE_GRAY: begin
            e.red = r; e.green = r; e.blue = r; e.alpha = ONE;
         end
         MODE_INV_GRAY: begin
            e.red = ONE - r; e.green = ONE - r; e.blue = ONE - r; e.alpha = ONE;
         end
         MODE_RED:       begin e.red = r; e.alpha = ONE; end
         MODE_GREEN:     begin e.green = r; e.alpha = ONE; end
         MODE_BLUE:      begin e.blue = r; e.alpha = ONE; end
         MODE_ALPHA:     e.alpha = r;
         MODE_HSV_HUE:   begin h = r; hsv = 1'b1; end
         MODE_HSV_HUEV:  begin h = r; v = r; hsv = 1'b1; end
         MODE_HSV_SAT:   begin s = r; hsv = 1'b1; end
         MODE_HSV_VAL:   begin v = r; hsv = 1'b1; end
         MODE_HSV_ALPHA: begin a = r; hsv = 1'b1; end
         default: ;
      endcase
      if (hsv) begin
         h6 = 20'(h) * 20'd6;
         sector = h6[19:16];
         f = {1'b0, h6[15:0]};
         // hue of one wraps to the red sector
         if (sector >= 4'd6) begin
            sector = 4'd0; f = '0;
         end
         p = fix_mul(v, ONE - s);
         q = fix_mul(v, ONE - fix_mul(f, s));
         t = fix_mul(v, ONE - fix_mul(ONE - f, s));
         case (sector)
            4'd0: begin e.red = v; e.green = t; e.blue = p; end
            4'd1: begin e.red = q; e.green = v; e.blue = p; end
            4'd2: begin e.red = p; e.green = v; e.blue = t; end
            4'd3: begin e.red = p; e.green = q; e.blue = v; end
            4'd4: begin e.red = t; e.green = p; e.blue = v; end
            default: begin e.red = v; e.green = p; e.blue = q; end
         endcase
         e.alpha = a;
      end
      e.row_out = rq.row_index;
      e.slice_out = rq.slice_index;
      return e;
   endfunction

   // Response side: random stall bursts, compare each beat with the oldest
   // expected entry
   int stall_left = 0;
   int free_left = 0;
   always @(posedge clock) begin
      cmrg_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (expected_entries.size() == 0) begin
               report_mismatch("beat with nothing expected", 17'h0, 17'h0);
            end else begin
               want = expected_entries.pop_front();
               if (rsp_data.red !== want.red) report_mismatch("red", rsp_data.red, want.red);
               if (rsp_data.green !== want.green)
                  report_mismatch("green", rsp_data.green, want.green);
               if (rsp_data.blue !== want.blue)
                  report_mismatch("blue", rsp_data.blue, want.blue);
               if (rsp_data.alpha !== want.alpha)
                  report_mismatch("alpha", rsp_data.alpha, want.alpha);
               if (rsp_data.row_out !== want.row_out)
                  report_mismatch("row", 17'(rsp_data.row_out), 17'(want.row_out));
               if (rsp_data.slice_out !== want.slice_out)
                  report_mismatch("slice", 17'(rsp_data.slice_out), 17'(want.slice_out));
            end
         end
         // advance the stall pattern: a burst, then a free stretch
         if (calm) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            rsp_stall <= 1'b0;
         end else begin
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 17);
            free_left = $urandom_range(0, 40);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: count cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // One write beat, then an idle wait with csr_valid low, so back to back
   // writes never drive csr_valid twice in the same step
   task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MODE:        sh_mode  = val[3:0];
         CSR_RANGE_LOW:   sh_low   = val;
         CSR_RANGE_HIGH:  sh_high  = val;
         CSR_CONST_HUE:   sh_hue   = val;
         CSR_CONST_SAT:   sh_sat   = val;
         CSR_CONST_VAL:   sh_val   = val;
         CSR_CONST_ALPHA: sh_alpha = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold until the pipe has drained, plus a latency margin
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_entries.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Send one beat; the prediction is taken with the current registers.
   // When check_fixed is set the typed-in entry is queued instead.
   task automatic send_row(input cmrg_req_type rq, input bit gaps,
                           input bit check_fixed, input cmrg_rsp_type fixed);
      int gap;
      if (gaps && !calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 17);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall);
      expected_entries.push_back(check_fixed ? fixed : predict_entry(rq));
      beats_in++;
   endtask

   function automatic logic [16:0] rand_q16();
      case ($urandom_range(0, 5))
         0: return 17'h0;
         1: return 17'h10000;
         2: return 17'h1FFFF;   // saturates to one
         3: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   typedef struct {
      logic [3:0]   mode;
      logic [16:0]  low;
      logic [16:0]  high;
      cmrg_req_type rq;
      bit           fixed;
      cmrg_rsp_type want;
   } directed_row_type;

   directed_row_type dir_rows[$];

   function automatic cmrg_rsp_type entry(logic [16:0] r, logic [16:0] g,
                                          logic [16:0] b, logic [16:0] a,
                                          logic [7:0] row, logic [3:0] sl);
      cmrg_rsp_type e;
      e.red = r; e.green = g; e.blue = b; e.alpha = a;
      e.row_out = row; e.slice_out = sl;
      return e;
   endfunction

   function automatic directed_row_type drow(logic [3:0] m, logic [16:0] lo,
                                             logic [16:0] hi, logic [7:0] row,
                                             logic [3:0] sl, bit fx,
                                             cmrg_rsp_type w);
      directed_row_type d;
      d.mode = m; d.low = lo; d.high = hi;
      d.rq.row_index = row; d.rq.slice_index = sl;
      d.fixed = fx; d.want = w;
      return d;
   endfunction

   initial begin
      cmrg_rsp_type none;
      cmrg_req_type rq;
      int           k, phase_len;
      none = '0;
      sh_mode = MODE_GRAY; sh_low = 0; sh_high = ONE;
      sh_hue = 0; sh_sat = ONE; sh_val = ONE; sh_alpha = ONE;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows after reset: gray ramp with full range
      send_row('{8'd0, 4'd0}, 0, 1, entry(0, 0, 0, ONE, 0, 0));
      send_row('{8'd128, 4'd15}, 0, 1, entry(32768, 32768, 32768, ONE, 128, 15));
      send_row('{8'd255, 4'd5}, 0, 1, entry(65280, 65280, 65280, ONE, 255, 5));
      drain();
      write_reg(CSR_CONST_HUE, 17'h1FFFF);   // hue above one saturates, wraps
      write_reg(CSR_CONST_SAT, ONE);
      write_reg(CSR_CONST_VAL, ONE);
      write_reg(CSR_CONST_ALPHA, 17'd1234);

      // mode, low, high, row, slice, typed-in flag, entry
      dir_rows.push_back(drow(MODE_BLACK, 0, ONE, 8'd77, 4'd3, 1,
                              entry(0, 0, 0, 0, 77, 3)));
      dir_rows.push_back(drow(4'd15, 0, ONE, 8'd200, 4'd9, 1,
                              entry(0, 0, 0, 0, 200, 9)));
      dir_rows.push_back(drow(MODE_INV_GRAY, 0, ONE, 8'd0, 4'd1, 1,
                              entry(ONE, ONE, ONE, ONE, 0, 1)));
      dir_rows.push_back(drow(MODE_RED, 0, ONE, 8'd64, 4'd2, 1,
                              entry(16384, 0, 0, ONE, 64, 2)));
      dir_rows.push_back(drow(MODE_GREEN, 0, ONE, 8'd64, 4'd2, 1,
                              entry(0, 16384, 0, ONE, 64, 2)));
      dir_rows.push_back(drow(MODE_BLUE, 0, ONE, 8'd64, 4'd2, 1,
                              entry(0, 0, 16384, ONE, 64, 2)));
      dir_rows.push_back(drow(MODE_ALPHA, 0, ONE, 8'd64, 4'd2, 1,
                              entry(0, 0, 0, 16384, 64, 2)));
      // equal range ends: a step at half level
      dir_rows.push_back(drow(MODE_GRAY, 32768, 32768, 8'd127, 4'd0, 1,
                              entry(0, 0, 0, ONE, 127, 0)));
      dir_rows.push_back(drow(MODE_GRAY, 32768, 32768, 8'd128, 4'd0, 1,
                              entry(ONE, ONE, ONE, ONE, 128, 0)));
      // reversed ends: ramp falls with the row
      dir_rows.push_back(drow(MODE_GRAY, ONE, 0, 8'd64, 4'd4, 0, none));
      dir_rows.push_back(drow(MODE_GRAY, 17'h1FFFF, 17'h1FFFF, 8'd255, 4'd4, 1,
                              entry(0, 0, 0, ONE, 255, 4)));
      dir_rows.push_back(drow(MODE_GRAY, 0, 17'd256, 8'd200, 4'd4, 1,
                              entry(ONE, ONE, ONE, ONE, 200, 4)));
      dir_rows.push_back(drow(MODE_HSV_HUE, 0, ONE, 8'd255, 4'd6, 0, none));
      dir_rows.push_back(drow(MODE_HSV_HUE, 0, ONE, 8'd100, 4'd6, 0, none));
      dir_rows.push_back(drow(MODE_HSV_HUEV, 0, ONE, 8'd180, 4'd7, 0, none));
      dir_rows.push_back(drow(MODE_HSV_SAT, 0, ONE, 8'd30, 4'd8, 0, none));
      dir_rows.push_back(drow(MODE_HSV_VAL, 0, ONE, 8'd90, 4'd10, 0, none));
      dir_rows.push_back(drow(MODE_HSV_ALPHA, 0, ONE, 8'd220, 4'd11, 0, none));

      foreach (dir_rows[i]) begin
         if (dir_rows[i].mode != sh_mode || dir_rows[i].low != sh_low ||
             dir_rows[i].high != sh_high) begin
            drain();
            write_reg(CSR_MODE, 17'(dir_rows[i].mode));
            write_reg(CSR_RANGE_LOW, dir_rows[i].low);
            write_reg(CSR_RANGE_HIGH, dir_rows[i].high);
         end
         send_row(dir_rows[i].rq, 0, dir_rows[i].fixed, dir_rows[i].want);
      end

      // Random phases: fresh settings, then a run of random rows
      k = 0;
      while (k < N_RANDOM) begin
         drain();
         settings_run++;
         write_reg(CSR_MODE, 17'($urandom_range(0, 15)));
         if ($urandom_range(0, 2) == 0) begin
            write_reg(CSR_RANGE_LOW, 17'h0);
            write_reg(CSR_RANGE_HIGH, ONE);
         end else begin
            write_reg(CSR_RANGE_LOW, rand_q16());
            write_reg(CSR_RANGE_HIGH, rand_q16());
         end
         write_reg(CSR_CONST_HUE, rand_q16());
         write_reg(CSR_CONST_SAT, rand_q16());
         write_reg(CSR_CONST_VAL, rand_q16());
         write_reg(CSR_CONST_ALPHA, rand_q16());
         calm = (k > N_RANDOM - 120);
         phase_len = $urandom_range(20, 90);
         repeat (phase_len) begin
            rq.row_index   = 8'($urandom_range(0, 255));
            rq.slice_index = 4'($urandom_range(0, 15));
            send_row(rq, 1, 0, none);
            k++;
         end
         // hold off once until every result is back, then go on
         if (settings_run == 3) begin
            req_valid <= 1'b0;
            while (expected_entries.size() != 0) @(posedge clock);
            @(posedge clock);
         end
      end

      req_valid <= 1'b0;
      while (expected_entries.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      $display("covered %0d request beats, %0d response beats, %0d random settings",
               beats_in, beats_out, settings_run);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
